// File: sv/etb_pkg.sv
// Shared types and constants for the elimination tree builder.
package etb_pkg;

  // Node and column index width; the stores hold one entry per node.
  localparam int NODE_W = 10;
  localparam int DEPTH  = 1 << NODE_W;

  // One nonzero entry of the matrix pattern.
  typedef struct packed {
    logic [NODE_W-1:0] row_index;
    logic [NODE_W-1:0] col_index;
    logic              new_matrix;
  } in_item_t;

  // One (child, parent) link of the tree.
  typedef struct packed {
    logic [NODE_W-1:0] child_node;
    logic [NODE_W-1:0] parent_node;
  } out_item_t;

  // Store entry: a node number with its valid flag ("none" when clear).
  typedef struct packed {
    logic              vld;
    logic [NODE_W-1:0] val;
  } entry_t;

  // Result handed from the engine to the output register.
  typedef struct packed {
    logic      valid;
    out_item_t data;
  } emit_t;

endpackage

// File: sv/elimination_tree_builder_top.sv
// Top level of the elimination tree builder: channels, mode register, output register.
//
// Input channel in_valid/in_stall/in_data carries one nonzero (row, column,
// new_matrix) per transaction, columns in nondecreasing order. Output channel
// out_valid/out_stall/out_data carries one (child, parent) link when an entry
// fixes a parent; most entries produce none. cfg_wen/cfg_wdata writes the
// ata_mode bit (0: tree of A, 1: tree of A'A).
// An entry passes through the start state (and the last-column lookup in ata_mode),
// then walks the ancestor path node by node; the single-port read of the ancestor
// store sets that pace, one node per cycle, with a hold at the final node while the
// output register is full. A result appears in the output register the cycle after
// the walk ends. Reset clears the mode and runs a clearing pass over all 1024
// entries of both stores with in_stall high. An entry with new_matrix set runs the
// same pass before it is processed. When the receiver stalls, the result holds in
// the output register; the walk that finds the next result waits on it.
module elimination_tree_builder_top
  import etb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wen,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic  ata_mode;
  logic  eng_idle;
  logic  out_free;
  emit_t emit;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      ata_mode <= 1'b0;
    end else if (cfg_wen) begin
      ata_mode <= cfg_wdata;
    end
  end

  assign in_stall = !eng_idle;
  assign out_free = !out_valid || !out_stall;

  etb_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .ata_mode (ata_mode),
    .start    (in_valid && eng_idle),
    .item     (in_data),
    .out_free (out_free),
    .idle     (eng_idle),
    .emit     (emit)
  );

  // Output register: load a new link, drop the valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data <= emit.data;
    end
  end

endmodule

// File: sv/etb_engine.sv
// Tree walk engine: ancestor and last-column stores with the walk sequencer.
module etb_engine
  import etb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     ata_mode,
  input  logic     start,
  input  in_item_t item,
  input  logic     out_free,
  output logic     idle,
  output emit_t    emit
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_START = 5'b00100,
    ST_LAST  = 5'b01000,
    ST_WALK  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [NODE_W-1:0] clr_addr, clr_addr_next;
  logic              pend, pend_next;
  logic [NODE_W-1:0] row, row_next;
  logic [NODE_W-1:0] col, col_next;
  logic [NODE_W-1:0] node, node_next;

  // Stores
  entry_t            anc_mem  [DEPTH];
  entry_t            last_mem [DEPTH];
  entry_t            anc_rdata, last_rdata;
  logic [NODE_W-1:0] anc_raddr;
  logic              anc_we, last_we;
  logic [NODE_W-1:0] anc_waddr, last_waddr;
  entry_t            anc_wdata, last_wdata;

  // Read, modify and write back. A walk never advances to the entry it writes in
  // the same cycle: a stored ancestor is always above its node.
  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[anc_waddr] <= anc_wdata;
    end
    anc_rdata <= anc_mem[anc_raddr];
  end

  always_ff @(posedge clk) begin
    if (last_we) begin
      last_mem[last_waddr] <= last_wdata;
    end
    last_rdata <= last_mem[row];
  end

  // Sequence clearing, start, last-column lookup and the ancestor walk
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    pend_next     = pend;
    row_next      = row;
    col_next      = col;
    node_next     = node;
    anc_raddr     = node;
    anc_we        = 1'b0;
    anc_waddr     = node;
    anc_wdata     = '{vld: 1'b1, val: col};
    last_we       = 1'b0;
    last_waddr    = row;
    last_wdata    = '{vld: 1'b1, val: col};
    emit          = '0;
    emit.data     = '{child_node: node, parent_node: col};

    case (state)
      ST_CLEAR: begin
        anc_we        = 1'b1;
        anc_waddr     = clr_addr;
        anc_wdata     = '0;
        last_we       = 1'b1;
        last_waddr    = clr_addr;
        last_wdata    = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == NODE_W'(DEPTH - 1)) begin
          state_next = pend ? ST_START : ST_IDLE;
          pend_next  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          row_next = item.row_index;
          col_next = item.col_index;
          if (item.new_matrix) begin
            state_next = ST_CLEAR;
            pend_next  = 1'b1;
          end else begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        if (ata_mode) begin
          state_next = ST_LAST;
        end else if (row < col) begin
          node_next  = row;
          anc_raddr  = row;
          state_next = ST_WALK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LAST: begin
        // Record this column for the row and start from the previous one
        last_we = 1'b1;
        if (last_rdata.vld && (last_rdata.val < col)) begin
          node_next  = last_rdata.val;
          anc_raddr  = last_rdata.val;
          state_next = ST_WALK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (!anc_rdata.vld) begin
          // Unlinked node: link it to the column, hold while output is full
          if (out_free) begin
            anc_we     = 1'b1;
            emit.valid = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          // Compress the path and advance while below the column
          anc_we = 1'b1;
          if (anc_rdata.val < col) begin
            node_next = anc_rdata.val;
            anc_raddr = anc_rdata.val;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pend     <= pend_next;
    end
    row  <= row_next;
    col  <= col_next;
    node <= node_next;
  end

  assign idle = (state == ST_IDLE);

endmodule
